/* src/bqo_pkg.sv */
// bqo_pkg: shared types, constants and the quarter-wave sine table for the
// biquad resonator / dds tone generator; no dependencies
package bqo_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 32;
    localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [PHASE_BITS-1:0]         t_phase;
    typedef logic [SINE_TABLE_BITS-1:0]    t_tidx;
    typedef logic [SINE_TABLE_BITS-3:0]    t_qidx;
    typedef logic signed [15:0]            t_sample;
    typedef logic signed [31:0]            t_q30;
    typedef t_sample                       t_qtab [QUARTER];

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PHASE_STEP   = 2'd0,
        CFG_IMPULSE_GAIN = 2'd1,
        CFG_FEEDBACK_ONE = 2'd2,
        CFG_FEEDBACK_TWO = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] phase_step;
        t_q30        impulse_gain;
        t_q30        feedback_one;
        t_q30        feedback_two;
    } t_cfg;

    localparam logic [31:0] RST_PHASE_STEP   = 32'd134217728;
    localparam t_q30        RST_IMPULSE_GAIN = 32'sd21080773;
    localparam t_q30        RST_FEEDBACK_ONE = -32'sd2147069184;
    localparam t_q30        RST_FEEDBACK_TWO = 32'sd1073741824;

    // pipeline step controls handed from the top level to the datapath units
    typedef struct packed {
        logic s1_adv;    // item leaves the input register, state updates
        logic restart;   // restart flag of that item
        logic out_load;  // result register loads
    } t_pipe_ctl;

    // sin(pi/2 * m / QUARTER) * 32767, rounded, from a fixed Q30 series
    function automatic t_sample f_quarter_sine(input int unsigned m);
        longint unsigned lm;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned one;
        longint unsigned t;
        lm  = 64'(m);
        x   = (lm * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
        x2  = (x * x) >> 30;
        one = 64'd1 << 30;
        t   = one;
        t   = one - ((x2 * t) >> 30) / 110;
        t   = one - ((x2 * t) >> 30) / 72;
        t   = one - ((x2 * t) >> 30) / 42;
        t   = one - ((x2 * t) >> 30) / 20;
        t   = one - ((x2 * t) >> 30) / 6;
        t   = (x * t) >> 30;
        return t_sample'((t * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic t_qtab f_build_qtab();
        t_qtab tab;
        for (int m = 0; m < QUARTER; m++) begin
            tab[m] = f_quarter_sine(m);
        end
        return tab;
    endfunction

    localparam t_qtab   QTAB = f_build_qtab();
    localparam t_sample QTOP = f_quarter_sine(QUARTER);

    // full-turn sine from the quarter table by folding
    function automatic t_sample f_table_sine(input t_tidx k);
        logic [1:0] q;
        t_qidx      r;
        t_sample    mag;
        q = k[SINE_TABLE_BITS-1 -: 2];
        r = k[SINE_TABLE_BITS-3:0];
        if (q[0] && r == '0) begin
            mag = QTOP;
        end else if (q[0]) begin
            mag = QTAB[t_qidx'(0) - r];
        end else begin
            mag = QTAB[r];
        end
        return q[1] ? -mag : mag;
    endfunction

endpackage

/* src/bqo_in_if.sv */
// bqo_in_if: input channel carrying the restart flag
// depends on nothing
interface bqo_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

/* src/bqo_out_if.sv */
// bqo_out_if: result channel with the three 16-bit samples
// depends on nothing
interface bqo_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] resonator_sample;
    logic signed [15:0] sine_sample;
    logic signed [15:0] cosine_sample;

    modport source (output valid, output resonator_sample, output sine_sample,
                    output cosine_sample, input ready);
    modport sink   (input valid, input resonator_sample, input sine_sample,
                    input cosine_sample, output ready);
endinterface

/* src/bqo_resonator.sv */
// bqo_resonator: two-pole resonator recurrence, history state and output scaling
// depends on bqo_pkg
module bqo_resonator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bqo_pkg::t_pipe_ctl i_ctl,
    input  bqo_pkg::t_cfg      i_cfg,
    output bqo_pkg::t_sample   o_sample
);

    localparam logic signed [65:0] ROUND_HALF = 66'sd1 <<< 29;
    localparam logic signed [47:0] TRUNC_BIAS = (48'sd1 <<< 30) - 48'sd1;

    bqo_pkg::t_q30 r_prev_one;
    bqo_pkg::t_q30 r_prev_two;
    logic          r_imp_pending;
    bqo_pkg::t_q30 r_nv;
    bqo_pkg::t_sample r_sample;

    bqo_pkg::t_q30      w_prev_one;
    bqo_pkg::t_q30      w_prev_two;
    logic               w_impulse;
    logic signed [63:0] w_p1;
    logic signed [63:0] w_p2;
    logic signed [65:0] w_imp;
    logic signed [65:0] w_sum;
    logic signed [35:0] w_hi;
    bqo_pkg::t_q30      w_nv;
    logic signed [47:0] w_scaled;
    logic signed [47:0] w_trunc;
    logic signed [17:0] w_res;
    bqo_pkg::t_sample   w_sample;

    // restart clears history and re-arms the impulse for this transaction
    assign w_prev_one = i_ctl.restart ? '0 : r_prev_one;
    assign w_prev_two = i_ctl.restart ? '0 : r_prev_two;
    assign w_impulse  = i_ctl.restart | r_imp_pending;

    assign w_p1  = i_cfg.feedback_one * w_prev_one;
    assign w_p2  = i_cfg.feedback_two * w_prev_two;
    assign w_imp = w_impulse ? (66'(i_cfg.impulse_gain) <<< 30) : '0;
    assign w_sum = ROUND_HALF + w_imp - 66'(w_p1) - 66'(w_p2);
    assign w_hi  = w_sum[65:30];

    always_comb begin
        if (w_hi[35:31] == {5{w_hi[35]}}) begin
            w_nv = w_hi[31:0];
        end else if (w_hi[35]) begin
            w_nv = 32'sh8000_0000;
        end else begin
            w_nv = 32'sh7fff_ffff;
        end
    end

    // times 32767, truncated toward zero, then clamp to 16 bits
    assign w_scaled = (48'(r_nv) <<< 15) - 48'(r_nv);
    assign w_trunc  = w_scaled + (w_scaled[47] ? TRUNC_BIAS : 48'sd0);
    assign w_res    = w_trunc[47:30];

    always_comb begin
        if (w_res > 18'sd32767) begin
            w_sample = 16'sh7fff;
        end else if (w_res < -18'sd32768) begin
            w_sample = 16'sh8000;
        end else begin
            w_sample = w_res[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_one    <= '0;
            r_prev_two    <= '0;
            r_imp_pending <= 1'b1;
        end else if (i_ctl.s1_adv) begin
            r_prev_one    <= w_nv;
            r_prev_two    <= w_prev_one;
            r_imp_pending <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_adv) begin
            r_nv <= w_nv;
        end
        if (i_ctl.out_load) begin
            r_sample <= w_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

/* src/bqo_dds.sv */
// bqo_dds: phase accumulator and folded sine/cosine table lookup
// depends on bqo_pkg
module bqo_dds (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bqo_pkg::t_pipe_ctl i_ctl,
    input  bqo_pkg::t_cfg      i_cfg,
    output bqo_pkg::t_sample   o_sine,
    output bqo_pkg::t_sample   o_cosine
);

    localparam bqo_pkg::t_tidx COS_OFFSET = bqo_pkg::t_tidx'(bqo_pkg::QUARTER);

    bqo_pkg::t_phase  r_phase;
    bqo_pkg::t_tidx   r_k;
    bqo_pkg::t_sample r_sine;
    bqo_pkg::t_sample r_cosine;

    bqo_pkg::t_phase  n_phase;

    assign n_phase = r_phase + bqo_pkg::t_phase'(i_cfg.phase_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_ctl.s1_adv) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_adv) begin
            r_k <= n_phase[bqo_pkg::PHASE_BITS-1 -: bqo_pkg::SINE_TABLE_BITS];
        end
        if (i_ctl.out_load) begin
            r_sine   <= bqo_pkg::f_table_sine(r_k);
            r_cosine <= bqo_pkg::f_table_sine(r_k + COS_OFFSET);
        end
    end

    assign o_sine   = r_sine;
    assign o_cosine = r_cosine;

endmodule

/* src/biquad_oscillator_and_dds_tone.sv */
// biquad_oscillator_and_dds_tone: resonator oscillator (left) and dds tone (right)
// an accepted transaction passes the input register, stage 2 and the result register
// throughput: one transaction per cycle; ready follows the pipeline fill and, through
// the result register, o_out.ready, so a full pipeline stalls only while o_out.ready is low
// reset (synchronous, active low): empty pipeline, history and phase zero,
// impulse armed, configuration registers at their default values
module biquad_oscillator_and_dds_tone (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bqo_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [bqo_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    bqo_in_if.sink                              i_in,
    bqo_out_if.source                           o_out
);

    bqo_pkg::t_cfg      r_cfg;
    logic               r_s1_valid;
    logic               r_s1_restart;
    logic               r_s2_valid;
    logic               r_out_valid;

    logic               n_s1_valid;
    logic               n_s2_valid;
    logic               n_out_valid;

    logic               w_en_out;
    logic               w_s2_free;
    logic               w_in_acc;
    bqo_pkg::t_pipe_ctl w_ctl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step   <= bqo_pkg::RST_PHASE_STEP;
            r_cfg.impulse_gain <= bqo_pkg::RST_IMPULSE_GAIN;
            r_cfg.feedback_one <= bqo_pkg::RST_FEEDBACK_ONE;
            r_cfg.feedback_two <= bqo_pkg::RST_FEEDBACK_TWO;
        end else if (i_cfg_we) begin
            unique case (bqo_pkg::t_cfg_idx'(i_cfg_idx))
                bqo_pkg::CFG_PHASE_STEP:   r_cfg.phase_step   <= i_cfg_data;
                bqo_pkg::CFG_IMPULSE_GAIN: r_cfg.impulse_gain <= i_cfg_data;
                bqo_pkg::CFG_FEEDBACK_ONE: r_cfg.feedback_one <= i_cfg_data;
                bqo_pkg::CFG_FEEDBACK_TWO: r_cfg.feedback_two <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance chain, result register back to input register
    assign w_en_out  = !r_out_valid || o_out.ready;
    assign w_s2_free = !r_s2_valid || w_en_out;
    assign w_ctl.out_load = r_s2_valid && w_en_out;
    assign w_ctl.s1_adv   = r_s1_valid && w_s2_free;
    assign w_ctl.restart  = r_s1_restart;

    assign i_in.ready = !r_s1_valid || w_s2_free;
    assign w_in_acc   = i_in.valid && i_in.ready;

    assign n_s1_valid  = w_in_acc || (r_s1_valid && !w_ctl.s1_adv);
    assign n_s2_valid  = w_ctl.s1_adv || (r_s2_valid && !w_en_out);
    assign n_out_valid = w_ctl.out_load || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_restart <= i_in.restart;
        end
    end

    bqo_resonator u_resonator (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg    (r_cfg),
        .o_sample (o_out.resonator_sample)
    );

    bqo_dds u_dds (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg    (r_cfg),
        .o_sine   (o_out.sine_sample),
        .o_cosine (o_out.cosine_sample)
    );

    assign o_out.valid = r_out_valid;

endmodule

/* src/bqo_checker.sv */
// bqo_checker: port-level assertions for the tone generator, bound to the top level
// depends on the top level's ports only
module bqo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_res_sample,
    input logic [15:0] i_sin_sample,
    input logic [15:0] i_cos_sample
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_res_sample) && $stable(i_sin_sample)
            && $stable(i_cos_sample))
        else $error("stalled result changed");

    // with the result side taking, the pipeline never blocks input
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output is ready");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("pipeline not empty after reset");

    // table magnitudes stay within 32767
    a_table_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_sin_sample != 16'h8000 && i_cos_sample != 16'h8000)
        else $error("table sample out of range");

endmodule

bind biquad_oscillator_and_dds_tone bqo_checker u_bqo_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_res_sample (o_out.resonator_sample),
    .i_sin_sample (o_out.sine_sample),
    .i_cos_sample (o_out.cosine_sample)
);

/* tb/bqo_tone_checker.sv */
// bqo_tone_checker: watches the config port and both channels of the tone generator,
// predicts each stereo result and compares it; depends on bqo_pkg, bqo_in_if, bqo_out_if
`timescale 1ns / 100ps

module bqo_tone_checker
    import bqo_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    bqo_in_if                        i_in,
    bqo_out_if                       i_out,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_compared
);

    typedef struct packed {
        t_sample resonator;
        t_sample sine;
        t_sample cosine;
    } t_tones;

    // predicted configuration and state
    logic [31:0] step_reg;
    t_q30        gain_reg;
    t_q30        fb1_reg;
    t_q30        fb2_reg;
    t_phase      phase;
    t_q30        hist1;
    t_q30        hist2;
    logic        kick;

    t_tones      tones_due [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        // keep the log short once things go wrong
        if (o_fail_count < 40) begin
            $display("%0t ns mismatch %s: got %0d, want %0d", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    // sin(pi/2 * m / QUARTER) scaled by 32767 with the Q30 series evaluation
    function automatic t_sample quarter_wave(input int unsigned m);
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned acc;
        longint unsigned unity;
        int unsigned     divs [5];
        divs  = '{110, 72, 42, 20, 6};
        unity = 64'd1 << 30;
        ang   = (64'(m) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
        ang2  = (ang * ang) >> 30;
        acc   = unity;
        for (int i = 0; i < 5; i++) begin
            acc = unity - ((ang2 * acc) >> 30) / divs[i];
        end
        acc = (ang * acc) >> 30;
        return t_sample'((acc * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic t_sample wave_at(input t_tidx k);
        logic [1:0]  quad;
        int unsigned off;
        int unsigned m;
        t_sample     mag;
        quad = k[SINE_TABLE_BITS-1 -: 2];
        off  = k[SINE_TABLE_BITS-3:0];
        m    = quad[0] ? QUARTER - off : off;
        mag  = quarter_wave(m);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic t_tones step_tones(input logic restart);
        longint          prod1;
        longint          prod2;
        longint          upper;
        longint unsigned lower;
        longint          scaled;
        longint          level;
        t_tidx           k;
        t_tones          tones;
        if (restart) begin
            hist1 = '0;
            hist2 = '0;
            kick  = 1'b1;
        end
        // exact Q4.60 sum, rounded to Q2.30 half up
        prod1 = -(longint'(fb1_reg) * longint'(hist1));
        prod2 = -(longint'(fb2_reg) * longint'(hist2));
        upper = (prod1 >>> 30) + (prod2 >>> 30);
        if (kick) begin
            upper += longint'(gain_reg);
        end
        lower = (unsigned'(prod1) & 64'h3FFF_FFFF) + (unsigned'(prod2) & 64'h3FFF_FFFF)
              + (64'd1 << 29);
        upper += signed'(lower >> 30);
        if (upper > 64'sd2147483647) begin
            upper = 64'sd2147483647;
        end else if (upper < -64'sd2147483648) begin
            upper = -64'sd2147483648;
        end
        hist2 = hist1;
        hist1 = t_q30'(upper);
        kick  = 1'b0;

        // scale by 32767, truncate toward zero, clamp to 16 bits
        scaled = upper * 32767;
        level  = (scaled >= 0) ? (scaled >>> 30) : -((-scaled) >>> 30);
        if (level > 32767) begin
            level = 32767;
        end else if (level < -32768) begin
            level = -32768;
        end
        tones.resonator = t_sample'(level);

        phase        = t_phase'(phase + step_reg);
        k            = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
        tones.sine   = wave_at(k);
        tones.cosine = wave_at(t_tidx'(k + QUARTER));
        return tones;
    endfunction

    always @(posedge i_clk) begin
        t_tones want;
        if (!i_rst_n) begin
            step_reg = RST_PHASE_STEP;
            gain_reg = RST_IMPULSE_GAIN;
            fb1_reg  = RST_FEEDBACK_ONE;
            fb2_reg  = RST_FEEDBACK_TWO;
            phase    = '0;
            hist1    = '0;
            hist2    = '0;
            kick     = 1'b1;
            tones_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PHASE_STEP:   step_reg = i_cfg_data;
                    CFG_IMPULSE_GAIN: gain_reg = t_q30'(i_cfg_data);
                    CFG_FEEDBACK_ONE: fb1_reg  = t_q30'(i_cfg_data);
                    CFG_FEEDBACK_TWO: fb2_reg  = t_q30'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                tones_due.push_back(step_tones(i_in.restart));
            end
            if (i_out.valid && i_out.ready) begin
                if (tones_due.size() == 0) begin
                    report_mismatch("unexpected result transaction", 1, 0);
                end else begin
                    want = tones_due.pop_front();
                    if (i_out.resonator_sample !== want.resonator) begin
                        report_mismatch("resonator_sample", i_out.resonator_sample,
                                        want.resonator);
                    end
                    if (i_out.sine_sample !== want.sine) begin
                        report_mismatch("sine_sample", i_out.sine_sample, want.sine);
                    end
                    if (i_out.cosine_sample !== want.cosine) begin
                        report_mismatch("cosine_sample", i_out.cosine_sample, want.cosine);
                    end
                    o_compared <= o_compared + 1;
                end
            end
        end
        o_pending <= tones_due.size();
    end

endmodule

/* tb/testbench.sv */
// testbench: drives restart ticks and register settings into the tone generator
// with random gaps and output stalls; depends on bqo_pkg, the channel interfaces,
// the block itself and bqo_tone_checker
`timescale 1ns / 100ps

module testbench;
    import bqo_pkg::*;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     sink_ready = 1'b0;
    bit                       steady;

    int fail_count;
    int pending;
    int compared;
    int sent_items;
    int restart_items;
    int settings;

    bqo_in_if  in_ch ();
    bqo_out_if out_ch ();

    assign out_ch.ready = sink_ready;

    biquad_oscillator_and_dds_tone uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    bqo_tone_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // output back-pressure
    always @(posedge clk) begin
        int stall_left;
        if (stall_left > 0) begin
            sink_ready <= 1'b0;
            stall_left--;
        end else begin
            sink_ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    task automatic push_tick(input logic restart);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart;
        do @(posedge clk); while (!in_ch.ready);
        sent_items++;
        if (restart) begin
            restart_items++;
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // writes all four registers on consecutive edges
    task automatic load_settings(input logic [31:0] step, input logic [31:0] gain,
                                 input logic [31:0] fb1, input logic [31:0] fb2);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_PHASE_STEP;
        cfg_data <= step;
        @(posedge clk);
        cfg_idx  <= CFG_IMPULSE_GAIN;
        cfg_data <= gain;
        @(posedge clk);
        cfg_idx  <= CFG_FEEDBACK_ONE;
        cfg_data <= fb1;
        @(posedge clk);
        cfg_idx  <= CFG_FEEDBACK_TWO;
        cfg_data <= fb2;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings++;
    endtask

    task automatic random_settings();
        logic [31:0] step;
        logic [31:0] gain;
        logic [31:0] fb1;
        logic [31:0] fb2;
        logic [31:0] r;
        case ($urandom_range(0, 3))
            0:       step = $urandom_range(1, 1 << 24);
            1:       step = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
            default: step = $urandom;
        endcase
        if ($urandom_range(0, 9) < 6) begin
            // near-marginal resonator so the tone keeps ringing
            r    = $urandom;
            gain = {{4{r[31]}}, r[31:4]};
            fb1  = -32'($urandom_range(0, 32'h7FFF_FFFF));
            fb2  = 32'h4000_0000 - $urandom_range(0, 1 << 20);
        end else begin
            gain = $urandom;
            fb1  = $urandom;
            fb2  = $urandom;
        end
        load_settings(step, gain, fb1, fb2);
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_PHASE_STEP;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.restart = 1'b0;
        steady        = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // default settings: impulse armed by reset, then a restart
        repeat (4) push_tick(1'b0);
        push_tick(1'b1);
        repeat (3) push_tick(1'b0);
        wait_idle();

        // growing recurrence saturates high, phase runs backwards
        load_settings(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        repeat (3) push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b0);
        wait_idle();

        // alternating blow-up hits both rails, phase frozen
        load_settings(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_tick(1'b1);
        repeat (4) push_tick(1'b0);
        wait_idle();

        // unit impulse with no feedback, quarter-turn steps land on the fold points
        load_settings(32'h4000_0000, 32'h4000_0000, 32'h0000_0000, 32'h0000_0000);
        push_tick(1'b1);
        repeat (3) push_tick(1'b0);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            steady <= (ph == 3);
            random_settings();
            for (int n = 0; n < 100; n++) begin
                if (ph == 2 && n == 50) begin
                    wait_idle();
                end
                push_tick(n == 0 || $urandom_range(0, 24) == 0);
            end
            wait_idle();
        end

        repeat (8) @(posedge clk);
        $display("covered %0d transactions with %0d restarts over %0d register settings",
                 sent_items, restart_items, settings);
        $display("%0d results compared, %0d mismatches", compared, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results still outstanding", pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/bqo_pkg.sv
src/bqo_in_if.sv
src/bqo_out_if.sv
src/bqo_resonator.sv
src/bqo_dds.sv
src/biquad_oscillator_and_dds_tone.sv
src/bqo_checker.sv
tb/bqo_tone_checker.sv
tb/testbench.sv
